[rtl/core/sliding_window_statistics_defines.svh]
// Assertion macros for the sliding window statistics block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_DEFINES_SVH
`ifndef SYNTHESIS
// check outside reset
`define SWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that also holds across reset
`define SWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SWS_ASSERT(lbl, prop, msg)
`define SWS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/sws_pkg.sv]
// Shared types and constants for the sliding window statistics block.
// No dependencies.
package sws_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int REG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int WS_W       = 5;
  localparam int RL_W       = 16;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RECORD_LENGTH = 1'b1;
  localparam logic [WS_W-1:0] WS_RESET = 5'd4;
  localparam logic [RL_W-1:0] RL_RESET = 16'hFFFF;

  // step counter carried in commands
  localparam int CNT_W = 8;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHIFT,
    OP_SCAN,
    OP_PREP,
    OP_NMUL,
    OP_VLOAD,
    OP_DIV_STEP,
    OP_SQ_LOAD,
    OP_SQ_STEP,
    OP_MLOAD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/sws_ctrl.sv]
// Sequencer for the sliding window statistics block.
// Depends on sws_pkg.
module sws_ctrl #(
  parameter int WINDOW_MAX  = sws_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = sws_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sws_pkg::sts_t sts,
  output sws_pkg::cmd_t cmd
);

  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_BITS + NW;
  localparam int NUM_W = 2 * SAMPLE_BITS + 2 * NW;
  localparam int SQ_H  = NUM_W / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PREP, S_NMUL, S_VLOAD, S_VDIV,
    S_SQLD, S_SQRT, S_MLD, S_MDIV, S_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [sws_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd.op    = sws_pkg::OP_NONE;
    cmd.cnt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          cmd.op    = sws_pkg::OP_SHIFT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = sws_pkg::OP_SCAN;
        if (sts.scan_last) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = sws_pkg::OP_PREP;
        cnt_nxt   = '0;
        state_nxt = S_NMUL;
      end
      S_NMUL: begin
        cmd.op = sws_pkg::OP_NMUL;
        if (cnt_r == sws_pkg::CNT_W'(NW - 1)) begin
          state_nxt = S_VLOAD;
        end
      end
      S_VLOAD: begin
        cmd.op    = sws_pkg::OP_VLOAD;
        cnt_nxt   = '0;
        state_nxt = S_VDIV;
      end
      S_VDIV: begin
        cmd.op = sws_pkg::OP_DIV_STEP;
        if (cnt_r == sws_pkg::CNT_W'(NUM_W - 1)) begin
          state_nxt = S_SQLD;
        end
      end
      S_SQLD: begin
        cmd.op    = sws_pkg::OP_SQ_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = sws_pkg::OP_SQ_STEP;
        if (cnt_r == sws_pkg::CNT_W'(SQ_H - 1)) begin
          state_nxt = S_MLD;
        end
      end
      S_MLD: begin
        cmd.op    = sws_pkg::OP_MLOAD;
        cnt_nxt   = '0;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        cmd.op = sws_pkg::OP_DIV_STEP;
        if (cnt_r == sws_pkg::CNT_W'(SUM_W - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = sws_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/core/sws_datapath.sv]
// Datapath: sample history, window scan, serial multiply, shared divider,
// square root, configuration and output registers. Depends on sws_pkg.
module sws_datapath #(
  parameter int WINDOW_MAX  = sws_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = sws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sws_pkg::cmd_t                       cmd,
  output sws_pkg::sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                cfg_wr_en,
  input  logic [sws_pkg::REG_IDX_W-1:0]       cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       window_min,
  output logic signed [SAMPLE_BITS-1:0]       window_mean,
  output logic signed [SAMPLE_BITS-1:0]       window_max,
  output logic signed [SAMPLE_BITS-1:0]       window_median,
  output logic [SAMPLE_BITS-1:0]              std_dev,
  output logic                                status
);

  localparam int SB    = SAMPLE_BITS;
  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int IDXW  = $clog2(WINDOW_MAX);
  localparam int BW    = $clog2(NW);
  localparam int SUM_W = SB + NW;
  localparam int SQS_W = 2 * SB + NW;
  localparam int NUM_W = 2 * SB + 2 * NW;
  localparam int DIV_W = 2 * NW;
  localparam int SQ_H  = NUM_W / 2;

  function automatic logic [NW-1:0] popcnt(input logic [WINDOW_MAX-1:0] v);
    logic [NW-1:0] c;
    c = '0;
    for (int k = 0; k < WINDOW_MAX; k++) begin
      c = c + NW'(v[k]);
    end
    return c;
  endfunction

  // configuration registers
  logic [sws_pkg::WS_W-1:0] window_size_r;
  logic [sws_pkg::RL_W-1:0] record_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= sws_pkg::WS_RESET;
      record_length_r <= sws_pkg::RL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        sws_pkg::REG_WINDOW_SIZE:   window_size_r   <= cfg_wdata[sws_pkg::WS_W-1:0];
        sws_pkg::REG_RECORD_LENGTH: record_length_r <= cfg_wdata[sws_pkg::RL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 1..WINDOW_MAX
  logic [NW-1:0] n;
  always_comb begin
    if (window_size_r == '0) begin
      n = NW'(1);
    end else if (int'(window_size_r) > WINDOW_MAX) begin
      n = NW'(WINDOW_MAX);
    end else begin
      n = NW'(window_size_r);
    end
  end

  logic [NW-1:0] k_lo, k_hi;
  assign k_lo = (n - 1'b1) >> 1;
  assign k_hi = n >> 1;

  // history shift line, newest at position zero
  logic signed [SB-1:0] hist_r [WINDOW_MAX];
  logic                 seen_r;

  always_ff @(posedge clk) begin
    if (cmd.op == sws_pkg::OP_SHIFT) begin
      for (int k = 0; k < WINDOW_MAX; k++) begin
        if (!seen_r || k == 0) begin
          hist_r[k] <= sample;
        end else begin
          hist_r[k] <= hist_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (cmd.op == sws_pkg::OP_SHIFT) begin
      seen_r <= 1'b1;
    end
  end

  // window scan: one position per cycle, rank against all positions inside the window
  logic [IDXW-1:0]        idx;
  logic signed [SB-1:0]   v;
  logic signed [2*SB-1:0] v_sq;
  logic [WINDOW_MAX-1:0]  lt_vec, le_vec;
  logic [NW-1:0]          n_lt, n_le;

  assign idx  = cmd.cnt[IDXW-1:0];
  assign v    = hist_r[idx];
  assign v_sq = v * v;

  always_comb begin
    for (int k = 0; k < WINDOW_MAX; k++) begin
      lt_vec[k] = (k < int'(n)) && (hist_r[k] < v);
      le_vec[k] = (k < int'(n)) && (hist_r[k] <= v);
    end
  end
  assign n_lt = popcnt(lt_vec);
  assign n_le = popcnt(le_vec);

  assign sts.scan_last = (cmd.cnt == sws_pkg::CNT_W'(n - 1'b1));

  logic signed [SUM_W-1:0] sum_r;
  logic [SQS_W-1:0]        sumsq_r;
  logic signed [SB-1:0]    min_r, max_r, med_lo_r, med_hi_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      sws_pkg::OP_SHIFT: begin
        sum_r   <= '0;
        sumsq_r <= '0;
      end
      sws_pkg::OP_SCAN: begin
        sum_r   <= sum_r + SUM_W'(v);
        sumsq_r <= sumsq_r + SQS_W'($unsigned(v_sq));
        if (idx == '0 || v < min_r) begin
          min_r <= v;
        end
        if (idx == '0 || v > max_r) begin
          max_r <= v;
        end
        if (n_lt <= k_lo && k_lo < n_le) begin
          med_lo_r <= v;
        end
        if (n_lt <= k_hi && k_hi < n_le) begin
          med_hi_r <= v;
        end
      end
      default: ;
    endcase
  end

  // N*sum(x^2) by shift-add, sum^2 and N*(N-1)
  logic [NUM_W-1:0] sq2_r, nsq_r;
  logic [DIV_W-1:0] nn1_r;
  logic [BW-1:0]    mbit;

  assign mbit = cmd.cnt[BW-1:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      sws_pkg::OP_PREP: begin
        sq2_r <= NUM_W'(sum_r) * NUM_W'(sum_r);
        nn1_r <= DIV_W'(n) * DIV_W'(n - 1'b1);
        nsq_r <= '0;
      end
      sws_pkg::OP_NMUL: begin
        if (n[mbit]) begin
          nsq_r <= nsq_r + (NUM_W'(sumsq_r) << mbit);
        end
      end
      default: ;
    endcase
  end

  // shared restoring divider and digit-by-digit square root
  logic [NUM_W-1:0]    dq_r;
  logic [DIV_W-1:0]    dv_r, rem_r;
  logic [DIV_W:0]      d_try;
  logic [SQ_H-1:0]     root_r;
  logic [SQ_H+1:0]     srem_r, s_try, s_trial;
  logic [SUM_W-1:0]    sum_abs;

  assign d_try   = {rem_r, dq_r[NUM_W-1]};
  assign s_try   = {srem_r[SQ_H-1:0], dq_r[NUM_W-1 -: 2]};
  assign s_trial = {root_r, 2'b01};
  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    case (cmd.op)
      sws_pkg::OP_VLOAD: begin
        dq_r  <= nsq_r - sq2_r;
        dv_r  <= nn1_r;
        rem_r <= '0;
      end
      sws_pkg::OP_MLOAD: begin
        dq_r  <= NUM_W'(sum_abs) << (NUM_W - SUM_W);
        dv_r  <= DIV_W'(n);
        rem_r <= '0;
      end
      sws_pkg::OP_DIV_STEP: begin
        if (d_try >= {1'b0, dv_r}) begin
          rem_r <= DIV_W'(d_try - {1'b0, dv_r});
          dq_r  <= {dq_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= d_try[DIV_W-1:0];
          dq_r  <= {dq_r[NUM_W-2:0], 1'b0};
        end
      end
      sws_pkg::OP_SQ_LOAD: begin
        root_r <= '0;
        srem_r <= '0;
      end
      sws_pkg::OP_SQ_STEP: begin
        dq_r <= dq_r << 2;
        if (s_try >= s_trial) begin
          srem_r <= s_try - s_trial;
          root_r <= {root_r[SQ_H-2:0], 1'b1};
        end else begin
          srem_r <= s_try;
          root_r <= {root_r[SQ_H-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // result assembly
  logic [SUM_W-1:0]     quo;
  logic signed [SB-1:0] mean_v, med_v;
  logic signed [SB:0]   med_sum;
  logic [SB-1:0]        sd_v;
  logic                 status_v;

  assign quo      = dq_r[SUM_W-1:0];
  assign mean_v   = sum_r[SUM_W-1] ? SB'(-quo) : SB'(quo);
  assign med_sum  = (SB+1)'(med_lo_r) + (SB+1)'(med_hi_r);
  assign med_v    = med_sum[SB:1];
  always_comb begin
    if (n == NW'(1)) begin
      sd_v = '0;
    end else if (|root_r[SQ_H-1:SB]) begin
      sd_v = '1;
    end else begin
      sd_v = root_r[SB-1:0];
    end
  end
  assign status_v = (n == NW'(1)) || (sws_pkg::RL_W'(n) >= record_length_r);

  // output register
  logic                 out_valid_r;
  logic signed [SB-1:0] o_min_r, o_mean_r, o_max_r, o_med_r;
  logic [SB-1:0]        o_sd_r;
  logic                 o_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == sws_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sws_pkg::OP_OUT) begin
      o_min_r    <= min_r;
      o_mean_r   <= mean_v;
      o_max_r    <= max_r;
      o_med_r    <= med_v;
      o_sd_r     <= sd_v;
      o_status_r <= status_v;
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign window_min    = o_min_r;
  assign window_mean   = o_mean_r;
  assign window_max    = o_max_r;
  assign window_median = o_med_r;
  assign std_dev       = o_sd_r;
  assign status        = o_status_r;

endmodule

[rtl/core/sliding_window_statistics.sv]
// Sliding window statistics: min, mean, max, median, std dev per sample.
// Each input beat runs through the window scan, a bit-serial multiply, the divider
// (variance), the square root and the divider again (mean), then waits until the
// result register is free. No new beat is taken until that result is loaded.
// One item in flight.
// Synchronous active-low reset clears control, the first-sample flag, config and out valid.
`include "sliding_window_statistics_defines.svh"
module sliding_window_statistics #(
  parameter int WINDOW_MAX  = sws_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = sws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // sample
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          in_tdata,
  // window_min, window_mean, window_max, window_median, std_dev
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((5*SAMPLE_BITS+7)/8)*8-1:0]        out_tdata,
  // status
  output logic                                      out_tuser,
  input  logic                                      cfg_wr_en,
  input  logic [sws_pkg::REG_IDX_W-1:0]             cfg_addr,
  input  logic [sws_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((5 * SB + 7) / 8) * 8;

  sws_pkg::cmd_t cmd;
  sws_pkg::sts_t sts;

  logic signed [SB-1:0] w_min, w_mean, w_max, w_med;
  logic [SB-1:0]        w_sd;

  sws_ctrl #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sws_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (in_tdata[SB-1:0]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .window_min   (w_min),
    .window_mean  (w_mean),
    .window_max   (w_max),
    .window_median(w_med),
    .std_dev      (w_sd),
    .status       (out_tuser)
  );

  assign out_tdata = OUT_W'({w_sd, w_med, w_max, w_mean, w_min});

  // checks
  `SWS_ASSERT(a_one_in_flight, (in_tvalid && in_tready) |=> !in_tready, "second beat taken while busy")
  `SWS_ASSERT(a_result_at_end, $rose(out_tvalid) |-> in_tready, "result raised outside end of item")
  `SWS_ASSERT_ALWAYS(a_reset_state, !rst_n |=> (in_tready && !out_tvalid), "reset did not idle block")

endmodule

[bench/sliding_window_statistics_tb.sv]
// Self-checking bench for sliding_window_statistics: predicts min/mean/max/median/std dev.
// Depends on sws_pkg and the sliding_window_statistics RTL only.
module sliding_window_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WMAX = 16;

  typedef struct packed {
    logic        status;
    logic [15:0] sdev;
    logic [15:0] median;
    logic [15:0] wmax;
    logic [15:0] mean;
    logic [15:0] wmin;
  } stats_t;

  // window model and queue of predicted statistics
  class window_scoreboard;
    logic signed [15:0] hist[WMAX];
    int unsigned        seen;
    logic [4:0]         win_size;
    logic [15:0]        rec_len;
    stats_t             pending_stats[$];
    int                 errors;

    function new();
      seen = 0;
      win_size = sws_pkg::WS_RESET;
      rec_len = sws_pkg::RL_RESET;
      errors = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void write_reg(logic [sws_pkg::REG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == sws_pkg::REG_WINDOW_SIZE) win_size = val[4:0];
      else if (idx == sws_pkg::REG_RECORD_LENGTH) rec_len = val;
    endfunction

    // shift the sample in and predict one result beat
    function void note_sample(logic signed [15:0] x);
      longint srt[WMAX];
      longint sum, v, s, d, med;
      longint unsigned num, sd;
      int n, j;
      stats_t r;
      if (seen == 0) begin
        for (int i = 0; i < WMAX; i++) hist[i] = x;
      end else begin
        for (int i = WMAX - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = x;
      end
      if (seen < 65535) seen++;
      n = win_size;
      if (n < 1) n = 1;
      if (n > WMAX) n = WMAX;
      sum = 0;
      for (int i = 0; i < n; i++) begin
        v = hist[i];
        sum += v;
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      if (n % 2) begin
        med = srt[(n-1)/2];
      end else begin
        s = srt[n/2-1] + srt[n/2];
        med = s >>> 1;  // floor
      end
      num = 0;
      for (int i = 0; i < n; i++)
        for (int k = i + 1; k < n; k++) begin
          d = longint'(hist[i]) - longint'(hist[k]);
          if (d < 0) d = -d;
          num += longint'(d) * longint'(d);
        end
      if (n == 1) sd = 0;
      else sd = floor_sqrt(num / longint'(n * (n - 1)));
      if (sd > 65535) sd = 65535;
      r.wmin   = srt[0][15:0];
      r.wmax   = srt[n-1][15:0];
      r.mean   = 16'(sum / n);
      r.median = med[15:0];
      r.sdev   = sd[15:0];
      r.status = (n == 1 || n >= rec_len);
      pending_stats.push_back(r);
    endfunction

    function void check_beat(logic [79:0] data, logic user);
      stats_t e;
      if (pending_stats.size() == 0) begin
        $error("result beat with nothing predicted");
        errors++;
        return;
      end
      e = pending_stats.pop_front();
      if (data[15:0] !== e.wmin) begin
        $error("window_min exp %0h got %0h", e.wmin, data[15:0]); errors++;
      end
      if (data[31:16] !== e.mean) begin
        $error("window_mean exp %0h got %0h", e.mean, data[31:16]); errors++;
      end
      if (data[47:32] !== e.wmax) begin
        $error("window_max exp %0h got %0h", e.wmax, data[47:32]); errors++;
      end
      if (data[63:48] !== e.median) begin
        $error("window_median exp %0h got %0h", e.median, data[63:48]); errors++;
      end
      if (data[79:64] !== e.sdev) begin
        $error("std_dev exp %0h got %0h", e.sdev, data[79:64]); errors++;
      end
      if (user !== e.status) begin
        $error("status exp %0h got %0h", e.status, user); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [79:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [sws_pkg::REG_IDX_W-1:0]  cfg_addr;
  logic [sws_pkg::CFG_DATA_W-1:0] cfg_wdata;

  window_scoreboard sb;
  int tx_idle_pct, rx_idle_pct;
  bit hold_req;

  sliding_window_statistics dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // long stop in case the block hangs
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = 600;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_sample(logic [15:0] s);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  // wait until every result is back, then past the block's latency
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(logic [sws_pkg::REG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample(int flavor);
    case (flavor)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corners[10];
    int cfg_ws[8];
    int cfg_rl[8];
    int ws, rl;
    sb = new();
    hold_req = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 48;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= sws_pkg::REG_WINDOW_SIZE;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window of four, extremes and first-sample fill
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0100};
    foreach (corners[i]) send_sample(corners[i]);

    // directed settings: window of one, zero, oversize, record length edges
    cfg_ws = '{1, 16, 0, 17, 31, 2, 3, 8};
    cfg_rl = '{65535, 65535, 5, 0, 16, 2, 4, 1};
    foreach (cfg_ws[i]) begin
      drain();
      write_cfg(sws_pkg::REG_WINDOW_SIZE, 16'(cfg_ws[i]));
      write_cfg(sws_pkg::REG_RECORD_LENGTH, 16'(cfg_rl[i]));
      send_sample(16'h8000);
      send_sample(16'h7FFF);
    end

    // long receiver hold-off while samples keep coming
    hold_req = 1;
    repeat (4) send_sample(16'($urandom));

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 48; rx_idle_pct = 15;
      end else if (ph == 7) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      drain();
      ws = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      case ($urandom_range(3))
        0: rl = $urandom_range(0, 20);
        1: rl = 65535;
        default: rl = $urandom_range(65535);
      endcase
      if (ph == 9) ws = 16;
      write_cfg(sws_pkg::REG_WINDOW_SIZE, 16'(ws));
      write_cfg(sws_pkg::REG_RECORD_LENGTH, 16'(rl));
      repeat (145) send_sample(rand_sample($urandom_range(15)));
    end

    drain();
    if (sb.errors == 0 && sb.pending_stats.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
